// ----- sv/point_in_triangle_list_test_assert.svh -----
// assertion macros for the point in triangle list test block
// used by the top level, no other dependency
`ifndef POINT_IN_TRIANGLE_LIST_TEST_ASSERT_SVH
`define POINT_IN_TRIANGLE_LIST_TEST_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent holds, consequent must hold in the same cycle
`define PITL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pitl assertion failed");
// antecedent holds, consequent must hold in the next cycle
`define PITL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pitl assertion failed");
`else
`define PITL_ASSERT_SAME(lbl, ante, cons)
`define PITL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/pitl_pkg.sv -----
// shared constants, codes and types of the point in triangle list test block
// no dependencies
`timescale 1ns / 1ps

package pitl_pkg;

    localparam int MAX_VERTICES  = 512;
    localparam int MAX_TRIANGLES = 512;
    localparam int COORD_WIDTH   = 20;

    localparam int VERT_AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TRI_AW    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int TRI_CNT_W = $clog2(MAX_TRIANGLES + 1);

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 9;
    localparam int COUNT_W  = 10;
    localparam int TOL_W    = 40;

    // doubled area arithmetic widths
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int AREA_W  = PROD_W;
    localparam int SUM_W   = AREA_W + 2;
    localparam int GAP_W   = SUM_W + 1;
    localparam int CMP_W   = (GAP_W > TOL_W) ? GAP_W : TOL_W;

    // tag cells from issue to the gap register
    localparam int PIPE_DEPTH = 7;

    localparam logic [OPCODE_W-1:0] OP_WR_VERTEX = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_TRI    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY     = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TOL_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOL   = 1'b1;

    // request tdata layout
    localparam int SLOT_LSB   = 0;
    localparam int X_LSB      = SLOT_LSB + INDEX_W;
    localparam int Z_LSB      = X_LSB + COORD_WIDTH;
    localparam int A_LSB      = Z_LSB + COORD_WIDTH;
    localparam int B_LSB      = A_LSB + INDEX_W;
    localparam int C_LSB      = B_LSB + INDEX_W;
    localparam int S_FIELDS_W = C_LSB + INDEX_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((INDEX_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] z;
        logic signed [COORD_WIDTH-1:0] x;
    } point_t;

    typedef struct packed {
        logic [INDEX_W-1:0] c;
        logic [INDEX_W-1:0] b;
        logic [INDEX_W-1:0] a;
    } corners_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [TRI_AW-1:0] idx;
    } tag_t;

endpackage

// ----- sv/pitl_cross.sv -----
// doubled area cell: |cross(q - p, r - p)| over three register stages
// depends on pitl_pkg
`timescale 1ns / 1ps

module pitl_cross import pitl_pkg::*; (
    input  logic              aclk,
    input  point_t            p,
    input  point_t            q,
    input  point_t            r,
    output logic [AREA_W-1:0] area
);

    logic signed [DIFF_W-1:0]  ux_reg, uz_reg, vx_reg, vz_reg;
    logic signed [PROD_W-1:0]  prod_a_reg, prod_b_reg;
    logic signed [CROSS_W-1:0] cross_val;
    logic [AREA_W-1:0]         area_reg, area_next;

    assign cross_val = CROSS_W'(prod_a_reg) - CROSS_W'(prod_b_reg);
    assign area_next = cross_val[CROSS_W-1] ? AREA_W'(-cross_val) : AREA_W'(cross_val);

    always_ff @(posedge aclk) begin
        ux_reg     <= DIFF_W'(q.x) - DIFF_W'(p.x);
        uz_reg     <= DIFF_W'(q.z) - DIFF_W'(p.z);
        vx_reg     <= DIFF_W'(r.x) - DIFF_W'(p.x);
        vz_reg     <= DIFF_W'(r.z) - DIFF_W'(p.z);
        prod_a_reg <= PROD_W'(ux_reg) * PROD_W'(vz_reg);
        prod_b_reg <= PROD_W'(uz_reg) * PROD_W'(vx_reg);
        area_reg   <= area_next;
    end

    assign area = area_reg;

endmodule

// ----- sv/pitl_cell.sv -----
// tag cell: one link of the chain that walks a triangle tag down the pipeline
// depends on pitl_pkg
`timescale 1ns / 1ps

module pitl_cell import pitl_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic kill,
    input  tag_t tag_in,
    output tag_t tag_out
);

    logic              valid_reg;
    logic              last_reg;
    logic [TRI_AW-1:0] idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= tag_in.valid && !kill;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= tag_in.last;
        idx_reg  <= tag_in.idx;
    end

    assign tag_out = '{valid: valid_reg, last: last_reg, idx: idx_reg};

endmodule

// ----- sv/point_in_triangle_list_test.sv -----
// top level of the point in triangle list test block
// depends on pitl_pkg, pitl_cross, pitl_cell and the assertion header
`timescale 1ns / 1ps
//
// usage
//   s_axis carries requests: tuser is the opcode (write vertex, write triangle,
//   query point), tdata the slot, point and corner fields. m_axis carries one
//   result per query: tuser is the inside flag, tdata the first hit triangle.
//   the configuration port sets the searched triangle count and the tolerance;
//   write it only while no query is in flight.
// throughput
//   a vertex or triangle write gives no result.
//   a query walks the triangle list one triangle per cycle through a chain of
//   seven tag cells (table read, vertex read, three area stages, sum, gap);
//   it stops at the first hit or the last searched triangle and holds the
//   input until its result enters the output register. a count of zero misses
//   without a walk.
// reset
//   count clears to zero, tolerance to 13; the tables keep whatever they hold
//   and must be written before they are used. there is no clearing pass.
// stall
//   one result register feeds m_axis; while it waits, writes and a new query
//   are still taken, and a finished query waits in the hold state.
//

`include "point_in_triangle_list_test_assert.svh"

module point_in_triangle_list_test import pitl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // slot, coord_x, coord_z, corner_a, corner_b, corner_c, zero pad
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [OPCODE_W-1:0]   s_axis_tuser,
    // result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit_triangle, zero pad
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    // inside_res
    output logic                  m_axis_tuser,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg, state_next;

    // configuration registers
    logic [COUNT_W-1:0] count_reg;
    logic [TOL_W-1:0]   tol_reg;

    // query context
    logic [TRI_CNT_W-1:0] n_reg, n_next;
    logic [TRI_CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic [TRI_CNT_W-1:0] n_sat;
    point_t               query_reg, query_next;

    // finished result waiting for the output register
    logic               res_inside_reg, res_inside_next;
    logic [INDEX_W-1:0] res_tri_reg, res_tri_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic               m_inside_reg;
    logic [INDEX_W-1:0] m_tri_reg;
    logic               out_load;

    // request decode
    logic               in_fire;
    logic [INDEX_W-1:0] in_slot;
    point_t             in_point;
    corners_t           in_corners;
    logic               wr_vert, wr_tri, query_go;

    // tables, one vertex copy per corner so the three reads happen together
    corners_t tri_mem    [MAX_TRIANGLES];
    point_t   vert_mem_a [MAX_VERTICES];
    point_t   vert_mem_b [MAX_VERTICES];
    point_t   vert_mem_c [MAX_VERTICES];

    corners_t tri_rd_reg;
    point_t   vert_rd_a_reg, vert_rd_b_reg, vert_rd_c_reg;
    logic     oob_a_reg, oob_b_reg, oob_c_reg;
    point_t   vert_a, vert_b, vert_c;

    // area datapath
    logic [AREA_W-1:0]       area_whole, area_abp, area_acp, area_bcp;
    logic [AREA_W-1:0]       whole_reg;
    logic [SUM_W-1:0]        parts_reg;
    logic signed [GAP_W-1:0] gap_reg;
    logic [GAP_W-1:0]        gap_abs;
    logic                    gap_ok;

    // tag chain and search control
    tag_t chain [PIPE_DEPTH+1];
    tag_t end_tag;
    logic issue, hit, exhausted, finish;

    // ---------------- request decode ----------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign in_slot      = s_axis_tdata[SLOT_LSB +: INDEX_W];
    assign in_point.x   = s_axis_tdata[X_LSB +: COORD_WIDTH];
    assign in_point.z   = s_axis_tdata[Z_LSB +: COORD_WIDTH];
    assign in_corners.a = s_axis_tdata[A_LSB +: INDEX_W];
    assign in_corners.b = s_axis_tdata[B_LSB +: INDEX_W];
    assign in_corners.c = s_axis_tdata[C_LSB +: INDEX_W];

    // writes to slots beyond a table are dropped; the unused opcode does nothing
    assign wr_vert  = in_fire && (s_axis_tuser == OP_WR_VERTEX)
                      && (32'(in_slot) < MAX_VERTICES);
    assign wr_tri   = in_fire && (s_axis_tuser == OP_WR_TRI)
                      && (32'(in_slot) < MAX_TRIANGLES);
    assign query_go = in_fire && (s_axis_tuser == OP_QUERY);

    // count above the table depth searches the whole table
    assign n_sat = (32'(count_reg) > MAX_TRIANGLES) ? TRI_CNT_W'(MAX_TRIANGLES)
                                                    : TRI_CNT_W'(count_reg);

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            tol_reg   <= TOL_W'(13);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_IDX_COUNT: count_reg <= COUNT_W'(cfg_wr_data);
                CFG_IDX_TOL:   tol_reg   <= TOL_W'(cfg_wr_data);
            endcase
        end
    end

    // ---------------- tables ----------------
    always_ff @(posedge aclk) begin
        if (wr_tri) begin
            tri_mem[TRI_AW'(in_slot)] <= in_corners;
        end
        tri_rd_reg <= tri_mem[TRI_AW'(issue_cnt_reg)];
    end

    always_ff @(posedge aclk) begin
        if (wr_vert) begin
            vert_mem_a[VERT_AW'(in_slot)] <= in_point;
            vert_mem_b[VERT_AW'(in_slot)] <= in_point;
            vert_mem_c[VERT_AW'(in_slot)] <= in_point;
        end
        vert_rd_a_reg <= vert_mem_a[VERT_AW'(tri_rd_reg.a)];
        vert_rd_b_reg <= vert_mem_b[VERT_AW'(tri_rd_reg.b)];
        vert_rd_c_reg <= vert_mem_c[VERT_AW'(tri_rd_reg.c)];
        oob_a_reg     <= 32'(tri_rd_reg.a) >= MAX_VERTICES;
        oob_b_reg     <= 32'(tri_rd_reg.b) >= MAX_VERTICES;
        oob_c_reg     <= 32'(tri_rd_reg.c) >= MAX_VERTICES;
    end

    // a corner past the vertex table stands at the origin
    assign vert_a = oob_a_reg ? '0 : vert_rd_a_reg;
    assign vert_b = oob_b_reg ? '0 : vert_rd_b_reg;
    assign vert_c = oob_c_reg ? '0 : vert_rd_c_reg;

    // ---------------- doubled areas ----------------
    pitl_cross u_whole (.aclk(aclk), .p(vert_a), .q(vert_b), .r(vert_c),
                        .area(area_whole));
    pitl_cross u_abp   (.aclk(aclk), .p(vert_a), .q(vert_b), .r(query_reg),
                        .area(area_abp));
    pitl_cross u_acp   (.aclk(aclk), .p(vert_a), .q(vert_c), .r(query_reg),
                        .area(area_acp));
    pitl_cross u_bcp   (.aclk(aclk), .p(vert_b), .q(vert_c), .r(query_reg),
                        .area(area_bcp));

    always_ff @(posedge aclk) begin
        whole_reg <= area_whole;
        parts_reg <= SUM_W'(area_abp) + SUM_W'(area_acp) + SUM_W'(area_bcp);
        gap_reg   <= $signed(GAP_W'(whole_reg)) - $signed(GAP_W'(parts_reg));
    end

    assign gap_abs = gap_reg[GAP_W-1] ? GAP_W'(-gap_reg) : GAP_W'(gap_reg);
    assign gap_ok  = CMP_W'(gap_abs) <= CMP_W'(tol_reg);

    // ---------------- tag chain ----------------
    assign end_tag   = chain[PIPE_DEPTH];
    assign hit       = (state_reg == ST_RUN) && end_tag.valid && gap_ok;
    assign exhausted = (state_reg == ST_RUN) && end_tag.valid && end_tag.last && !gap_ok;
    // first hit or last triangle ends the walk and flushes the chain
    assign finish    = hit || exhausted;
    assign issue     = (state_reg == ST_RUN) && (issue_cnt_reg < n_reg) && !finish;

    assign chain[0] = '{valid: issue,
                        last:  issue_cnt_reg == (n_reg - TRI_CNT_W'(1)),
                        idx:   TRI_AW'(issue_cnt_reg)};

    for (genvar i = 0; i < PIPE_DEPTH; i++) begin : g_cell
        pitl_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .kill    (finish),
            .tag_in  (chain[i]),
            .tag_out (chain[i+1])
        );
    end

    // ---------------- controller ----------------
    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        issue_cnt_next  = issue_cnt_reg;
        query_next      = query_reg;
        res_inside_next = res_inside_reg;
        res_tri_next    = res_tri_reg;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (query_go) begin
                    n_next          = n_sat;
                    issue_cnt_next  = '0;
                    query_next      = in_point;
                    res_inside_next = 1'b0;
                    res_tri_next    = '0;
                    // empty search is a miss straight away
                    state_next      = (n_sat == '0) ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    issue_cnt_next = issue_cnt_reg + TRI_CNT_W'(1);
                end
                if (finish) begin
                    res_inside_next = hit;
                    res_tri_next    = hit ? INDEX_W'(end_tag.idx) : '0;
                    state_next      = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        issue_cnt_reg  <= issue_cnt_next;
        query_reg      <= query_next;
        res_inside_reg <= res_inside_next;
        res_tri_reg    <= res_tri_next;
        if (out_load) begin
            m_inside_reg <= res_inside_reg;
            m_tri_reg    <= res_tri_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_inside_reg;
    assign m_axis_tdata  = M_DATA_W'(m_tri_reg);

    // ---------------- assertions ----------------
    // a finished walk parks the result and leaves no tag in the chain
    `PITL_ASSERT_NEXT(a_finish_flushes, finish, (state_reg == ST_HOLD) && !end_tag.valid)
    // results enter the output register only from the hold state
    `PITL_ASSERT_SAME(a_load_from_hold, $rose(m_axis_tvalid), $past(state_reg) == ST_HOLD)
    // no tag is in flight once the block takes requests again
    `PITL_ASSERT_SAME(a_idle_chain_empty, state_reg == ST_IDLE, !end_tag.valid)
    // a miss always reports triangle zero
    `PITL_ASSERT_SAME(a_miss_zero_index, m_axis_tvalid && !m_axis_tuser,
                      m_axis_tdata == '0)

endmodule

// ----- tb/point_in_triangle_list_test_test.sv -----
// self-checking bench for the point in triangle list test block: loads, queries and settings
// depends on pitl_pkg and the point_in_triangle_list_test top level
`timescale 1ns / 1ps

module point_in_triangle_list_test_test;
    import pitl_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [TOL_W-1:0]    TOL_MAX   = {TOL_W{1'b1}};
    localparam logic [TOL_W-1:0]    TOL_RESET = 40'd13;

    // cycles allowed after the last result before the block counts as idle
    localparam int SETTLE_CYCLES = 30;
    // one long receiver hold-off so the block fills and stalls its input
    localparam int LONG_STALL    = 1500;
    // cycles with no handshake at all before the run is declared hung
    localparam int QUIET_LIMIT   = 20000;

    // one request as queued for the driver
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  slot;
        point_t              pt;
        corners_t            cr;
    } request_t;

    // outcome of one point query
    typedef struct packed {
        logic               in_tri;
        logic [INDEX_W-1:0] hit_idx;
    } verdict_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [OPCODE_W-1:0]   s_axis_tuser  = OP_WR_VERTEX;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index  = CFG_IDX_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;

    point_in_triangle_list_test DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // slot, coord_x, coord_z, corner_a, corner_b, corner_c, zero pad
        .s_axis_tdata  (s_axis_tdata),
        // opcode
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // hit_triangle, zero pad
        .m_axis_tdata  (m_axis_tdata),
        // inside_res
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // shadow of the block as seen by accepted requests (used to predict)
    // ------------------------------------------------------------------
    point_t             vert_tab [MAX_VERTICES];
    corners_t           tri_tab  [MAX_TRIANGLES];
    logic [COUNT_W-1:0] tri_count_cfg = '0;
    logic [TOL_W-1:0]   tol_cfg       = TOL_RESET;

    // ------------------------------------------------------------------
    // generator view: what has been queued so far, so queries only touch
    // entries that were written earlier in the request stream
    // ------------------------------------------------------------------
    point_t             gen_vert   [MAX_VERTICES];
    corners_t           gen_tri    [MAX_TRIANGLES];
    bit                 vert_known [MAX_VERTICES];
    bit                 tri_known  [MAX_TRIANGLES];
    logic [INDEX_W-1:0] known_verts[$];
    int                 tri_prefix = 0;   // triangles 0 .. tri_prefix-1 all written

    request_t    requests_to_send[$];
    verdict_t    verdicts_due[$];
    int unsigned requests_pushed   = 0;
    int unsigned requests_accepted = 0;
    int unsigned results_taken     = 0;
    int unsigned mismatches        = 0;
    int unsigned hits_checked      = 0;
    int unsigned misses_checked    = 0;
    int unsigned vertex_writes     = 0;
    int unsigned tri_writes        = 0;
    int unsigned queries_sent      = 0;
    int unsigned ignored_sent      = 0;
    int unsigned settings_used     = 0;

    int send_gap        = 0;
    bit send_steady     = 1'b0;
    int stall_left      = 0;
    bit recv_steady     = 1'b0;
    bit long_stall_done = 1'b0;
    int quiet           = 0;

    // doubled area of (p, q, r): absolute 2d cross product, exact in 64 bits
    function automatic longint twice_area(point_t p, point_t q, point_t r);
        longint cp;
        cp = (longint'($signed(q.x)) - longint'($signed(p.x)))
           * (longint'($signed(r.z)) - longint'($signed(p.z)))
           - (longint'($signed(q.z)) - longint'($signed(p.z)))
           * (longint'($signed(r.x)) - longint'($signed(p.x)));
        return (cp < 0) ? -cp : cp;
    endfunction

    // walk the searched triangles in order, first one within tolerance wins
    function automatic verdict_t search_triangles(point_t p);
        verdict_t v;
        int       n;
        point_t   a, b, c;
        longint   whole, parts, gap;
        v.in_tri  = 1'b0;
        v.hit_idx = '0;
        n = (tri_count_cfg > MAX_TRIANGLES) ? MAX_TRIANGLES : int'(tri_count_cfg);
        for (int t = 0; t < n && !v.in_tri; t++) begin
            a = vert_tab[tri_tab[t].a];
            b = vert_tab[tri_tab[t].b];
            c = vert_tab[tri_tab[t].c];
            whole = twice_area(a, b, c);
            parts = twice_area(a, b, p) + twice_area(a, c, p) + twice_area(b, c, p);
            gap   = (whole > parts) ? whole - parts : parts - whole;
            if (gap <= longint'({24'd0, tol_cfg})) begin
                v.in_tri  = 1'b1;
                v.hit_idx = INDEX_W'(t);
            end
        end
        return v;
    endfunction

    // coordinate with the extremes and the area near the origin favored
    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        int v;
        case ($urandom_range(0, 15))
            0: v = -(1 << (COORD_WIDTH - 1));
            1: v = (1 << (COORD_WIDTH - 1)) - 1;
            2: v = int'($urandom_range(0, 2047)) - 1024;
            default: v = int'($urandom);
        endcase
        return COORD_WIDTH'(v);
    endfunction

    function automatic logic [INDEX_W-1:0] pick_vertex();
        return known_verts[$urandom_range(0, known_verts.size() - 1)];
    endfunction

    // every field random, callers overwrite the ones the opcode uses
    function automatic request_t noise_request(logic [OPCODE_W-1:0] op);
        request_t r;
        r.op   = op;
        r.slot = INDEX_W'($urandom);
        r.pt.x = COORD_WIDTH'($urandom);
        r.pt.z = COORD_WIDTH'($urandom);
        r.cr.a = INDEX_W'($urandom);
        r.cr.b = INDEX_W'($urandom);
        r.cr.c = INDEX_W'($urandom);
        return r;
    endfunction

    task automatic queue_request(input request_t r);
        case (r.op)
            OP_WR_VERTEX: begin
                gen_vert[r.slot] = r.pt;
                if (!vert_known[r.slot]) begin
                    vert_known[r.slot] = 1'b1;
                    known_verts = {known_verts, r.slot};
                end
                vertex_writes++;
            end
            OP_WR_TRI: begin
                gen_tri[r.slot]   = r.cr;
                tri_known[r.slot] = 1'b1;
                while (tri_prefix < MAX_TRIANGLES && tri_known[tri_prefix])
                    tri_prefix++;
                tri_writes++;
            end
            OP_QUERY: queries_sent++;
            default: ignored_sent++;
        endcase
        requests_to_send = {requests_to_send, r};
        requests_pushed++;
    endtask

    task automatic put_vertex(input int slot, input int x, input int z);
        request_t r;
        r      = noise_request(OP_WR_VERTEX);
        r.slot = INDEX_W'(slot);
        r.pt.x = COORD_WIDTH'(x);
        r.pt.z = COORD_WIDTH'(z);
        queue_request(r);
    endtask

    task automatic put_triangle(input int slot, input int a, input int b, input int c);
        request_t r;
        r      = noise_request(OP_WR_TRI);
        r.slot = INDEX_W'(slot);
        r.cr.a = INDEX_W'(a);
        r.cr.b = INDEX_W'(b);
        r.cr.c = INDEX_W'(c);
        queue_request(r);
    endtask

    task automatic put_query(input int x, input int z);
        request_t r;
        r      = noise_request(OP_QUERY);
        r.pt.x = COORD_WIDTH'(x);
        r.pt.z = COORD_WIDTH'(z);
        queue_request(r);
    endtask

    // registers change only with nothing in flight
    task automatic program_registers(input int tri_num, input logic [TOL_W-1:0] tol);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_IDX_COUNT;
        cfg_wr_data  <= CFG_DATA_W'(tri_num);
        @(posedge aclk);
        cfg_wr_index <= CFG_IDX_TOL;
        cfg_wr_data  <= tol;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        tri_count_cfg  = COUNT_W'(tri_num);
        tol_cfg        = tol;
        settings_used++;
    endtask

    // sender pause: everything accepted, every result back, then settle
    task automatic wait_idle();
        while (requests_accepted != requests_pushed || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly well-formed traffic: writes that keep the tables consistent and
    // queries aimed inside, on a corner of, or anywhere around the triangles
    task automatic random_phase(input int n_items);
        int     done;
        int     pick;
        int     t;
        int     n_eff;
        int     w1, w2, w3;
        int     a, b, c;
        point_t pa, pb, pc;
        done  = 0;
        n_eff = (tri_count_cfg > MAX_TRIANGLES) ? MAX_TRIANGLES : int'(tri_count_cfg);
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // unused opcode, the block drops it
                queue_request(noise_request(OP_UNUSED));
            end else begin
                done++;
                if (pick < 28) begin
                    put_vertex($urandom_range(0, MAX_VERTICES - 1),
                               $signed(rand_coord()), $signed(rand_coord()));
                end else if (pick < 52) begin
                    if (tri_prefix < MAX_TRIANGLES && $urandom_range(0, 1) == 0)
                        t = tri_prefix;
                    else
                        t = $urandom_range(0, MAX_TRIANGLES - 1);
                    a = pick_vertex();
                    b = pick_vertex();
                    c = pick_vertex();
                    // now and then a degenerate one: repeated corners
                    case ($urandom_range(0, 19))
                        0: b = a;
                        1: begin
                            b = a;
                            c = a;
                        end
                        default: ;
                    endcase
                    put_triangle(t, a, b, c);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (n_eff == 0 || pick < 40) begin
                        put_query($signed(rand_coord()), $signed(rand_coord()));
                    end else begin
                        t  = $urandom_range(0, n_eff - 1);
                        pa = gen_vert[gen_tri[t].a];
                        pb = gen_vert[gen_tri[t].b];
                        pc = gen_vert[gen_tri[t].c];
                        if (pick < 60) begin
                            put_query($signed(pa.x), $signed(pa.z));
                        end else begin
                            w1 = $urandom_range(0, 7);
                            w2 = $urandom_range(0, 7);
                            w3 = $urandom_range(0, 7);
                            if (w1 + w2 + w3 == 0)
                                w1 = 1;
                            put_query((w1 * $signed(pa.x) + w2 * $signed(pb.x)
                                       + w3 * $signed(pc.x)) / (w1 + w2 + w3),
                                      (w1 * $signed(pa.z) + w2 * $signed(pb.z)
                                       + w3 * $signed(pc.z)) / (w1 + w2 + w3));
                        end
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: pops the pending queue, random gap after each request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : request_driver
        request_t            nxt;
        logic [S_DATA_W-1:0] packed_data;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (requests_to_send.size() != 0) begin
                nxt         = requests_to_send.pop_front();
                packed_data = '0;
                packed_data[SLOT_LSB +: INDEX_W]  = nxt.slot;
                packed_data[X_LSB +: COORD_WIDTH] = nxt.pt.x;
                packed_data[Z_LSB +: COORD_WIDTH] = nxt.pt.z;
                packed_data[A_LSB +: INDEX_W]     = nxt.cr.a;
                packed_data[B_LSB +: INDEX_W]     = nxt.cr.b;
                packed_data[C_LSB +: INDEX_W]     = nxt.cr.c;
                s_axis_tdata  <= packed_data;
                s_axis_tuser  <= nxt.op;
                s_axis_tvalid <= 1'b1;
                // occasionally switch between gappy and back-to-back stretches
                if ($urandom_range(0, 31) == 0)
                    send_steady <= !send_steady;
                send_gap <= send_steady ? 0 : $urandom_range(0, 12);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // accepted requests update the shadow tables; queries get a verdict
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : request_monitor
        logic [INDEX_W-1:0] slot;
        point_t             pt;
        corners_t           cr;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            slot = s_axis_tdata[SLOT_LSB +: INDEX_W];
            pt.x = s_axis_tdata[X_LSB +: COORD_WIDTH];
            pt.z = s_axis_tdata[Z_LSB +: COORD_WIDTH];
            cr.a = s_axis_tdata[A_LSB +: INDEX_W];
            cr.b = s_axis_tdata[B_LSB +: INDEX_W];
            cr.c = s_axis_tdata[C_LSB +: INDEX_W];
            case (s_axis_tuser)
                OP_WR_VERTEX: vert_tab[slot] = pt;
                OP_WR_TRI:    tri_tab[slot] = cr;
                OP_QUERY:     verdicts_due = {verdicts_due, search_triangles(pt)};
                default: ;
            endcase
            requests_accepted++;
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random wait after each result, one long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_receiver
        int w;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (!long_stall_done && results_taken >= 20 && requests_to_send.size() > 30) begin
                // sender keeps offering while the result sits: input must back up
                long_stall_done <= 1'b1;
                stall_left      <= LONG_STALL;
                m_axis_tready   <= 1'b0;
            end else begin
                if ($urandom_range(0, 31) == 0)
                    recv_steady <= !recv_steady;
                w = recv_steady ? 0 : $urandom_range(0, 12);
                stall_left    <= w;
                m_axis_tready <= (w == 0);
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker: oldest verdict against each accepted result
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_checker
        verdict_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_taken++;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: in_tri=%0d hit=%0d, no query pending",
                             m_axis_tuser, m_axis_tdata[INDEX_W-1:0]);
            end else begin
                want = verdicts_due.pop_front();
                if (m_axis_tuser !== want.in_tri
                        || m_axis_tdata[INDEX_W-1:0] !== want.hit_idx) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: want in=%0d hit=%0d, got in=%0d hit=%0d",
                                 results_taken, want.in_tri, want.hit_idx,
                                 m_axis_tuser, m_axis_tdata[INDEX_W-1:0]);
                end
                if (want.in_tri)
                    hits_checked++;
                else
                    misses_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no handshake on any port means a hang
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || cfg_wr_en) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     quiet, verdicts_due.size());
            $display("point_in_triangle_list_test_test: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus: directed corners first, then random phases over settings
    // ------------------------------------------------------------------
    initial begin : stimulus
        int               tri_num;
        logic [TOL_W-1:0] tol;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: count zero, every query misses without any table read
        put_query(-524288, 524287);
        put_vertex(0, -524288, -524288);
        put_vertex(1, 524287, -524288);
        put_vertex(2, -524288, 524287);
        put_vertex(3, 0, 0);
        put_vertex(511, 524287, 524287);
        put_vertex(4, 256, -512);
        put_vertex(5, 1024, 768);
        put_triangle(0, 0, 1, 2);         // spans nearly the whole plane
        put_triangle(1, 0, 3, 511);       // collinear corners, zero area
        put_triangle(2, 3, 4, 5);
        put_triangle(3, 511, 511, 511);   // all corners the same vertex
        put_triangle(511, 511, 1, 2);     // top slot, top corner index
        queue_request(noise_request(OP_UNUSED));
        put_query(0, 0);
        wait_idle();

        // exact match only
        program_registers(3, '0);
        put_query(-100000, -100000);      // interior of the big one
        put_query(524287, -524288);       // exactly on a corner
        put_query(300, 300);              // on the zero-area line
        put_query(426, 85);               // centroid of the small one
        put_query(524287, 0);             // outside everything searched
        wait_idle();

        // widest tolerance, the point triangle now in the search
        program_registers(4, TOL_MAX);
        put_query(524287, 0);
        put_query(-524288, -524288);
        put_triangle(3, 2, 3, 4);         // replace the point triangle
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    tri_num = $urandom_range(1, (tri_prefix < 8) ? tri_prefix : 8);
                    tol     = TOL_RESET;
                end
                1: begin
                    tri_num = 0;
                    tol     = TOL_W'({$urandom, $urandom});
                end
                2: begin
                    tri_num = 1;
                    tol     = '0;
                end
                3: begin
                    tri_num = $urandom_range(1, (tri_prefix < 32) ? tri_prefix : 32);
                    tol     = TOL_MAX;
                end
                4: begin
                    tri_num = $urandom_range(1, tri_prefix);
                    tol     = TOL_W'($urandom_range(0, 65535));
                end
                default: begin
                    tri_num = $urandom_range(1, (tri_prefix < 16) ? tri_prefix : 16);
                    tol     = TOL_W'({$urandom, $urandom}) >> $urandom_range(0, TOL_W);
                end
            endcase
            program_registers(tri_num, tol);
            random_phase(75);
            wait_idle();
        end

        // fill every triangle slot so the full-length searches stay on written entries
        while (tri_prefix < MAX_TRIANGLES)
            put_triangle(tri_prefix, pick_vertex(), pick_vertex(), pick_vertex());
        wait_idle();

        program_registers(MAX_TRIANGLES, TOL_RESET);
        random_phase(60);
        wait_idle();

        // largest count field value, saturates to the table depth
        program_registers((1 << COUNT_W) - 1, TOL_W'({$urandom, $urandom}) >> 20);
        random_phase(60);
        wait_idle();

        $display("covered %0d requests: %0d vertex, %0d triangle, %0d query, %0d unused",
                 requests_pushed, vertex_writes, tri_writes, queries_sent, ignored_sent);
        $display("checked %0d hits and %0d misses over %0d register settings, %0d mismatches",
                 hits_checked, misses_checked, settings_used, mismatches);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("point_in_triangle_list_test_test: PASS");
        end else begin
            $display("point_in_triangle_list_test_test: FAIL");
        end
        $finish;
    end

endmodule
